>>> src/line_raster_with_depth_macros.svh
// Assertion helpers for the line raster block.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef LINE_RASTER_WITH_DEPTH_MACROS_SVH
`define LINE_RASTER_WITH_DEPTH_MACROS_SVH

// Same-cycle implication.
`define LRD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lrd_pkg.sv
package lrd_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  // Coordinate differences and line lengths.
  localparam int DELTA_W    = COORD_BITS + 1;
  // Bresenham error term, bounded by twice the major length.
  localparam int ERR_W      = DELTA_W + 3;
  localparam int DIV_CNT_W  = $clog2(DEPTH_BITS + 1);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_DIVIDE
  } lrd_state_t;

  typedef struct packed {
    logic                  start;
    logic [DEPTH_BITS-1:0] dividend;
    logic [DELTA_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DEPTH_BITS-1:0] quotient;
    logic [DELTA_W-1:0]    remainder;
  } div_result_t;

endpackage

>>> src/lrd_divider.sv
module lrd_divider
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output div_result_t res
);

  logic [DELTA_W-1:0]    divisor;
  logic [DELTA_W-1:0]    rem;
  logic [DEPTH_BITS-1:0] quo;
  logic [DIV_CNT_W-1:0]  count;
  logic                  busy;
  logic                  done;

  logic [DELTA_W:0]      shifted;
  logic                  fits;
  logic [DELTA_W:0]      diff;

  // One restoring step: bring down the next dividend bit, try a subtract.
  always_comb begin
    shifted = {rem, quo[DEPTH_BITS-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= DIV_CNT_W'(DEPTH_BITS);
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= req.dividend;
      end else if (busy) begin
        rem   <= fits ? diff[DELTA_W-1:0] : shifted[DELTA_W-1:0];
        quo   <= {quo[DEPTH_BITS-2:0], fits};
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

>>> src/line_raster_with_depth.sv
// Bresenham line rasterizer, all octants, with linearly interpolated depth.
// A load item (command 0) takes two endpoints and sets up a line; it yields
// no output and replaces any line in progress. Each advance item (command 1)
// yields one pixel, from the endpoint with the lower major coordinate up to,
// but not including, the other one; last marks the final pixel. Lines with
// |dy| < |dx| step along x, all others (equal slopes included) along y. A
// zero-length line, or an advance with no line active, yields nothing.
// Depth of pixel k is z0 + floor(dz*k/n), held exactly as a running
// quotient plus remainder accumulator. An advance's pixel is registered,
// so pixels stream at one per clock while the output side keeps up. A load
// passes these steps from its accept to the next accept: the accept cycle,
// which captures the endpoints, a setup step that orders them, a start step
// for the divider, 16 steps of the one-bit-per-cycle restoring divider that
// forms dz / n, and a step that folds its result into the line state; a
// zero-length line skips the divider and returns to idle after setup.
// in_stall stays high for all of these steps but the first.
`include "line_raster_with_depth_macros.svh"

module line_raster_with_depth
  import lrd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic        [DEPTH_BITS-1:0] start_depth,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic        [DEPTH_BITS-1:0] end_depth,
  // output items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic        [DEPTH_BITS-1:0] pixel_depth,
  output logic                         last
);

  lrd_state_t state, state_next;

  // Captured endpoints and raw differences.
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic        [DEPTH_BITS-1:0] z0, z1;
  logic signed [DELTA_W-1:0]    dx, dy;
  logic signed [DEPTH_BITS:0]   zd;

  // Line state.
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] minor_pos;
  logic [ERR_W-1:0]      error_term;
  logic [DELTA_W-1:0]    pixels_left;
  logic                  minor_dir_negative;
  logic                  steep_line;
  logic [DEPTH_BITS-1:0] depth_now;
  // Only the low bits matter: depth is added modulo 2^DEPTH_BITS.
  logic [DEPTH_BITS-1:0] depth_quotient;
  logic [DELTA_W-1:0]    depth_remainder;
  logic [DELTA_W-1:0]    depth_accum;
  logic [DELTA_W-1:0]    major_delta;
  logic [DELTA_W-1:0]    minor_delta;
  logic                  dz_neg;
  logic [DEPTH_BITS-1:0] dz_mag;

  logic in_fire, load_fire, adv_emit;

  div_req_t    div_req;
  div_result_t div_res;

  lrd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (command == CMD_LOAD);
  assign adv_emit  = in_fire && (command == CMD_ADVANCE) && (pixels_left != '0);

  // ---------------------------------------------------------------------------
  // Setup: choose the major axis and order the endpoints so it rises.
  // A negative major difference means the endpoints swap.
  // ---------------------------------------------------------------------------
  logic [DELTA_W-1:0]    adx, ady, len_sel, minor_sel;
  logic signed [DELTA_W-1:0] da, db;
  logic                  steep_sel, swap;
  logic [COORD_BITS-1:0] a0_sel, b0_sel;
  logic [DEPTH_BITS:0]   zd_abs;
  logic [ERR_W-1:0]      err_init;

  always_comb begin
    adx       = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
    ady       = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
    steep_sel = !(ady < adx);
    da        = steep_sel ? dy : dx;
    db        = steep_sel ? dx : dy;
    swap      = da[DELTA_W-1];
    len_sel   = steep_sel ? ady : adx;
    minor_sel = steep_sel ? adx : ady;
    if (steep_sel) begin
      a0_sel = swap ? y1 : y0;
      b0_sel = swap ? x1 : x0;
    end else begin
      a0_sel = swap ? x1 : x0;
      b0_sel = swap ? y1 : y0;
    end
    zd_abs   = zd[DEPTH_BITS] ? (DEPTH_BITS+1)'(-zd) : (DEPTH_BITS+1)'(zd);
    err_init = {2'b00, minor_sel, 1'b0} - {3'b000, len_sel};
  end

  // ---------------------------------------------------------------------------
  // Per-pixel step.
  // ---------------------------------------------------------------------------
  logic                  err_pos;
  logic [ERR_W-1:0]      minor2, major2, error_step;
  logic [DELTA_W:0]      accum_sum;
  logic                  depth_carry;
  logic [DELTA_W-1:0]    accum_step;
  logic [DEPTH_BITS-1:0] depth_step;
  logic [COORD_BITS-1:0] minor_step;

  always_comb begin
    err_pos     = !error_term[ERR_W-1] && (error_term != '0);
    minor2      = {2'b00, minor_delta, 1'b0};
    major2      = {2'b00, major_delta, 1'b0};
    error_step  = err_pos ? (error_term + minor2 - major2) : (error_term + minor2);
    minor_step  = minor_dir_negative ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
    accum_sum   = {1'b0, depth_accum} + {1'b0, depth_remainder};
    depth_carry = (accum_sum >= {1'b0, major_delta});
    accum_step  = depth_carry ? DELTA_W'(accum_sum - {1'b0, major_delta})
                              : accum_sum[DELTA_W-1:0];
    depth_step  = depth_now + depth_quotient + DEPTH_BITS'(depth_carry);
  end

  // Floor correction of the unsigned divide when dz is negative.
  logic                  rem_nz;
  logic [DEPTH_BITS-1:0] quot_fix;
  logic [DELTA_W-1:0]    rem_fix;

  always_comb begin
    rem_nz   = (div_res.remainder != '0);
    quot_fix = dz_neg ? (~div_res.quotient + DEPTH_BITS'(!rem_nz)) : div_res.quotient;
    rem_fix  = (dz_neg && rem_nz) ? (major_delta - div_res.remainder)
                                  : div_res.remainder;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (load_fire) state_next = ST_SETUP;
      ST_SETUP:  state_next = (len_sel == '0) ? ST_IDLE : ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_res.done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = (state != ST_IDLE) || (out_valid && out_stall);
    div_req.start    = (state == ST_START);
    div_req.dividend = dz_mag;
    div_req.divisor  = major_delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      pixels_left <= '0;
    end else begin
      state <= state_next;

      if (adv_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (load_fire) begin
        pixels_left <= '0;
      end else if (state == ST_SETUP) begin
        pixels_left <= len_sel;
      end else if (adv_emit) begin
        pixels_left <= pixels_left - 1'b1;
      end
    end
  end

  // Payload and line registers.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      x0 <= start_x;
      y0 <= start_y;
      z0 <= start_depth;
      x1 <= end_x;
      y1 <= end_y;
      z1 <= end_depth;
      dx <= DELTA_W'(end_x) - DELTA_W'(start_x);
      dy <= DELTA_W'(end_y) - DELTA_W'(start_y);
      zd <= {1'b0, end_depth} - {1'b0, start_depth};
    end

    if (state == ST_SETUP) begin
      steep_line         <= steep_sel;
      major_pos          <= a0_sel;
      minor_pos          <= b0_sel;
      major_delta        <= len_sel;
      minor_delta        <= minor_sel;
      minor_dir_negative <= (db[DELTA_W-1] ^ swap) && (db != '0);
      error_term         <= err_init;
      depth_now          <= swap ? z1 : z0;
      depth_accum        <= '0;
      depth_quotient     <= '0;
      depth_remainder    <= '0;
      dz_neg             <= (zd[DEPTH_BITS] ^ swap) && (zd != '0);
      dz_mag             <= zd_abs[DEPTH_BITS-1:0];
    end else if ((state == ST_DIVIDE) && div_res.done) begin
      depth_quotient  <= quot_fix;
      depth_remainder <= rem_fix;
    end else if (adv_emit) begin
      pixel_x     <= steep_line ? minor_pos : major_pos;
      pixel_y     <= steep_line ? major_pos : minor_pos;
      pixel_depth <= depth_now;
      last        <= (pixels_left == DELTA_W'(1));
      if (err_pos) begin
        minor_pos <= minor_step;
      end
      error_term  <= error_step;
      major_pos   <= major_pos + 1'b1;
      depth_now   <= depth_step;
      depth_accum <= accum_step;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Line ready and running; set up, divide still ahead.
  logic line_live, setup_clean;

  assign line_live   = (state == ST_IDLE) && (pixels_left != '0);
  assign setup_clean = (state == ST_SETUP) && (pixels_left == '0);

  `LRD_CHECK(a_div_done_in_divide, div_res.done, state == ST_DIVIDE, "stray divider done")
  `LRD_CHECK(a_accum_below_len, line_live, depth_accum < major_delta, "accumulator out of range")
  `LRD_CHECK(a_rem_below_len, line_live, depth_remainder < major_delta, "remainder out of range")
  `LRD_CHECK_NEXT(a_load_to_setup, load_fire, setup_clean, "load did not enter setup")

endmodule

>>> test/tb_line_raster_with_depth.sv
`timescale 1ns / 100ps

module tb_line_raster_with_depth;
  import lrd_pkg::*;

  // Useful items to aim for in the random part: loads plus advances that emit
  localparam int TARGET_ITEMS = 1600;
  // Output-side hold-off: starts once this many items have been taken
  localparam int HOLD_AFTER   = 700;
  localparam int HOLD_CYCLES  = 400;
  // Tail wait: a multiple of the load worst case, leaving margin for stray pixels
  localparam int TAIL_CYCLES  = 4 * (DEPTH_BITS + 4);
  localparam int MAX_WAIT     = 13;
  localparam int MAX_REPORTS  = 10;
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN    = -COORD_MAX - 1;
  localparam int DEPTH_MAX    = (1 << DEPTH_BITS) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [DEPTH_BITS-1:0] depth_t;

  // One input item; drain makes the sender wait for all pixels before it
  typedef struct {
    logic   cmd;
    coord_t x0;
    coord_t y0;
    depth_t z0;
    coord_t x1;
    coord_t y1;
    depth_t z1;
    bit     drain;
  } raster_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    depth_t                z;
    logic                  last;
  } pixel_t;

  // All inputs start known; the driver takes over after reset
  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   in_valid    = 1'b0;
  logic   in_stall;
  logic   command     = CMD_ADVANCE;
  coord_t start_x     = '0;
  coord_t start_y     = '0;
  depth_t start_depth = '0;
  coord_t end_x       = '0;
  coord_t end_y       = '0;
  depth_t end_depth   = '0;
  logic   out_valid;
  logic   out_stall   = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  depth_t pixel_depth;
  logic   last;

  line_raster_with_depth i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .start_x    (start_x),
    .start_y    (start_y),
    .start_depth(start_depth),
    .end_x      (end_x),
    .end_y      (end_y),
    .end_depth  (end_depth),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_depth(pixel_depth),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line predictor. Plain ints hold the Bresenham terms so that no
  // intermediate wraps; only the emitted fields are cut to port width.
  // ---------------------------------------------------------------------------
  int     major_at, minor_at, bres_err, steps_left;
  int     span_major, span_minor;
  int     dz_whole, dz_frac, frac_sum;   // depth step as floor quotient + remainder
  bit     minor_down, y_major;
  depth_t z_run;
  pixel_t expected_pixels[$];

  function automatic void clear_line();
    major_at   = 0;
    minor_at   = 0;
    bres_err   = 0;
    steps_left = 0;
    span_major = 0;
    span_minor = 0;
    dz_whole   = 0;
    dz_frac    = 0;
    frac_sum   = 0;
    minor_down = 1'b0;
    y_major    = 1'b0;
    z_run      = '0;
  endfunction

  function automatic void setup_line(coord_t x0, coord_t y0, depth_t z0,
                                     coord_t x1, coord_t y1, depth_t z1);
    int px0, py0, px1, py1, za, zb, a0, b0, a1, b1, t, adx, ady, dz;
    px0 = x0;
    py0 = y0;
    px1 = x1;
    py1 = y1;
    za  = z0;
    zb  = z1;
    adx = px1 - px0;
    ady = py1 - py0;
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    // equal slopes fall on the y-major side
    y_major = !(ady < adx);
    if (y_major) begin
      a0 = py0; b0 = px0; a1 = py1; b1 = px1;
    end else begin
      a0 = px0; b0 = py0; a1 = px1; b1 = py1;
    end
    // walk from the lower major coordinate; depth endpoints swap along
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
      t = za; za = zb; zb = t;
    end
    span_major = a1 - a0;
    span_minor = b1 - b0;
    minor_down = span_minor < 0;
    if (minor_down) span_minor = -span_minor;
    major_at   = a0;
    minor_at   = b0;
    bres_err   = 2 * span_minor - span_major;
    steps_left = span_major;
    z_run      = za[DEPTH_BITS-1:0];
    frac_sum   = 0;
    dz_whole   = 0;
    dz_frac    = 0;
    if (span_major > 0) begin
      dz       = zb - za;
      dz_whole = dz / span_major;
      dz_frac  = dz % span_major;
      // floor division for a falling depth
      if (dz_frac < 0) begin
        dz_frac += span_major;
        dz_whole--;
      end
    end
  endfunction

  // Returns 1 and the pixel when a line is active; else nothing moves.
  function automatic bit step_pixel(output pixel_t px);
    px = '0;
    if (steps_left <= 0) return 1'b0;
    px.x    = y_major ? minor_at[COORD_BITS-1:0] : major_at[COORD_BITS-1:0];
    px.y    = y_major ? major_at[COORD_BITS-1:0] : minor_at[COORD_BITS-1:0];
    px.z    = z_run;
    px.last = steps_left == 1;
    if (bres_err > 0) begin
      minor_at += minor_down ? -1 : 1;
      bres_err += 2 * (span_minor - span_major);
    end else begin
      bres_err += 2 * span_minor;
    end
    major_at++;
    steps_left--;
    z_run    += dz_whole[DEPTH_BITS-1:0];
    frac_sum += dz_frac;
    if (frac_sum >= span_major) begin
      frac_sum -= span_major;
      z_run    += 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  raster_item_t line_cmds[$];

  function automatic void push_load(int x0, int y0, int z0, int x1, int y1, int z1,
                                    bit drain = 1'b0);
    raster_item_t it;
    it.cmd   = CMD_LOAD;
    it.x0    = coord_t'(x0);
    it.y0    = coord_t'(y0);
    it.z0    = depth_t'(z0);
    it.x1    = coord_t'(x1);
    it.y1    = coord_t'(y1);
    it.z1    = depth_t'(z1);
    it.drain = drain;
    line_cmds.insert(line_cmds.size(), it);
  endfunction

  // Endpoint fields on an advance are junk; the block must ignore them.
  function automatic void push_advances(int count);
    raster_item_t it;
    for (int i = 0; i < count; i++) begin
      it.cmd   = CMD_ADVANCE;
      it.x0    = coord_t'($urandom);
      it.y0    = coord_t'($urandom);
      it.z0    = depth_t'($urandom);
      it.x1    = coord_t'($urandom);
      it.y1    = coord_t'($urandom);
      it.z1    = depth_t'($urandom);
      it.drain = 1'b0;
      line_cmds.insert(line_cmds.size(), it);
    end
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, DEPTH_MAX) % (1 << COORD_BITS)) + COORD_MIN;
  endfunction

  function automatic int rand_depth();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return DEPTH_MAX;
      default: return int'($urandom_range(0, DEPTH_MAX));
    endcase
  endfunction

  // Adds one line (or some noise) and returns how many useful items it holds.
  function automatic int add_random_line();
    int kind, x0, y0, x1, y1, dx, dy, n, adv;
    kind = $urandom_range(0, 15);
    // noise: advances that may land on an idle block or an old line
    if (kind == 0) begin
      push_advances($urandom_range(1, 3));
      return 0;
    end
    x0 = rand_coord();
    y0 = rand_coord();
    if (kind == 1) begin
      // far-apart endpoints, only the first few pixels
      x1 = rand_coord();
      y1 = rand_coord();
    end else begin
      dx = (kind == 2) ? 0 : int'($urandom_range(0, 48)) - 24;
      dy = (kind == 2) ? 0 : int'($urandom_range(0, 48)) - 24;
      x1 = x0 + dx;
      y1 = y0 + dy;
      if (x1 > COORD_MAX || x1 < COORD_MIN) x1 = x0 - dx;
      if (y1 > COORD_MAX || y1 < COORD_MIN) y1 = y0 - dy;
    end
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    n  = (dx > dy) ? dx : dy;
    if (kind == 1)      adv = $urandom_range(1, 6);
    else if (kind == 3) adv = $urandom_range(0, n);       // cut short by the next load
    else                adv = n + $urandom_range(0, 2);   // run past the end
    push_load(x0, y0, rand_depth(), x1, y1, rand_depth(), $urandom_range(0, 31) == 0);
    push_advances(adv);
    return 1 + ((adv < n) ? adv : n);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, random gaps, optional wait for drain
  // ---------------------------------------------------------------------------
  int items_sent     = 0;
  int send_gap       = 0;
  bit send_burst     = 1'b0;
  int pending_pixels = 0;    // registered copy of the expectation count

  // Per-item wait, 0..MAX_WAIT; burst mode gives stretches with no idling
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 49) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  always @(posedge clk) begin
    raster_item_t nxt;
    bit           fire;
    fire = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        items_sent++;
        send_gap = draw_wait(send_burst);
        // a drain item is never offered straight after an accept: the count
        // it waits on is a registered copy and lags the queue
        fire = send_gap == 0 && line_cmds.size() != 0 && !line_cmds[0].drain;
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else fire = line_cmds.size() != 0 && (!line_cmds[0].drain || pending_pixels == 0);
      end
      if (fire) begin
        nxt = line_cmds.pop_front();
        command     <= nxt.cmd;
        start_x     <= nxt.x0;
        start_y     <= nxt.y0;
        start_depth <= nxt.z0;
        end_x       <= nxt.x1;
        end_y       <= nxt.y1;
        end_depth   <= nxt.z1;
      end
      // a stalled item stays put
      if (!in_valid || !in_stall) in_valid <= fire;
    end
  end

  // ---------------------------------------------------------------------------
  // Long output hold-off, counted here; the monitor folds it into out_stall
  // ---------------------------------------------------------------------------
  int hold_left    = 0;
  int inputs_taken = 0;
  bit hold_used    = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      inputs_taken = 0;
      hold_used    = 1'b0;
    end else begin
      if (in_valid && !in_stall) inputs_taken++;
      if (!hold_used && inputs_taken >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_used = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted input, checks each accepted pixel
  // ---------------------------------------------------------------------------
  int mismatches   = 0;
  int pixels_seen  = 0;
  int lines_closed = 0;
  int loads_seen   = 0;
  int recv_wait    = 0;
  bit recv_burst   = 1'b0;

  always @(posedge clk) begin
    pixel_t got, want, fresh;
    if (rst) begin
      out_stall      <= 1'b0;
      pending_pixels <= 0;
      recv_wait      = 0;
      clear_line();
    end else begin
      // predict first so a same-edge result would still find its entry
      if (in_valid && !in_stall) begin
        if (command == CMD_LOAD) begin
          setup_line(start_x, start_y, start_depth, end_x, end_y, end_depth);
          loads_seen++;
        end else if (step_pixel(fresh)) begin
          expected_pixels.insert(expected_pixels.size(), fresh);
        end
      end
      if (out_valid && !out_stall) begin
        got.x    = pixel_x;
        got.y    = pixel_y;
        got.z    = pixel_depth;
        got.last = last;
        pixels_seen++;
        if (got.last === 1'b1) lines_closed++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected pixel x=%0d y=%0d z=%0d last=%b",
                     $realtime, $signed(got.x), $signed(got.y), got.z, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"[%0t] pixel %0d: expected x=%0d y=%0d z=%0d last=%b, ",
                        "got x=%0d y=%0d z=%0d last=%b"},
                       $realtime, pixels_seen,
                       $signed(want.x), $signed(want.y), want.z, want.last,
                       $signed(got.x), $signed(got.y), got.z, got.last);
          end
        end
        recv_wait = draw_wait(recv_burst);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall      <= recv_wait > 0 || hold_left > 0;
      pending_pixels <= expected_pixels.size();
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all items, release reset, wait for the last pixel
  // ---------------------------------------------------------------------------
  initial begin
    int  useful;
    bit  long_done;
    useful    = 0;
    long_done = 1'b0;

    // directed: advance with nothing loaded
    push_advances(1);
    // zero-length line emits nothing
    push_load(100, -100, 500, 100, -100, 900);
    push_advances(1);
    // shallow, rising; one advance past the end
    push_load(0, 0, 0, 4, 1, 100);
    push_advances(5);
    // equal slopes go y-major; endpoints arrive reversed, depth falls
    push_load(3, 3, DEPTH_MAX, 0, 0, 0);
    push_advances(3);
    // vertical, full depth swing
    push_load(10, -3, 0, 10, 2, DEPTH_MAX);
    push_advances(5);
    // corner to corner, replaced by the next load after two pixels
    push_load(COORD_MIN, COORD_MAX, DEPTH_MAX, COORD_MAX, COORD_MIN, 0);
    push_advances(2);
    // shallow with x falling, after a full drain of the output
    push_load(COORD_MAX, COORD_MIN, 0, COORD_MAX - 2, COORD_MIN + 1, DEPTH_MAX, 1'b1);
    push_advances(3);

    while (useful < TARGET_ITEMS) begin
      // a long line lands under the output hold-off so the block backs up
      if (!long_done && line_cmds.size() >= HOLD_AFTER - 20) begin
        push_load(-1000, 500, DEPTH_MAX, -800, 430, 3);
        push_advances(200);
        useful    += 201;
        long_done = 1'b1;
      end
      useful += add_random_line();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (line_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d items (%0d line loads, junk and idle advances among them).",
             items_sent, loads_seen);
    $display("Checked %0d pixels; %0d lines ran out to their last pixel.",
             pixels_seen, lines_closed);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The slowest legal run ends well before this watchdog fires
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
